/* hw/rtl/lphs_pkg.sv */
// Shared types and constants for the linear probing hash set core.
package lphs_pkg;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_QUERY  = 2'd2
    } req_t;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef enum logic [1:0] {
        TAG_EMPTY = 2'd0,
        TAG_LIVE  = 2'd1,
        TAG_DEAD  = 2'd2
    } tag_t;

    localparam int unsigned KEY_PORT_W = 16;
    localparam int unsigned SLOT_PORT_W = 6;

    // x / 10 == (x * DIV10_RECIP) >> DIV10_SHIFT for every x below 2**32
    localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
    localparam int unsigned DIV10_SHIFT = 35;

endpackage

/* hw/rtl/lphs_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module lphs_ram #(
    parameter int unsigned WIDTH = 18,
    parameter int unsigned DEPTH = 23
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/linear_probe_hash_set_core.sv */
// Top level of the linear probing hash set: hashing, probe sequencer and slot memory.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+--------------------------------------
//  request   | start / busy          | req_type[1:0], key[15:0]
//  result    | done (one-cycle beat) | found, changed, table_full, slot[5:0]
//
// A request runs the digit sum (one multiply by the reciprocal of ten and one
// subtract per digit), then the modulo by repeated subtraction of TABLE_SIZE,
// which also issues the first read, and then probes the slot memory one slot
// at a time, up to TABLE_SIZE probes.
// A reserved key or unknown request type gives its done beat in the cycle after it is accepted.
// Reset clears the per-slot valid flags at once, so no clearing pass is run.
// The result beat is not held; busy falls in the same cycle as done rises.
module linear_probe_hash_set_core
    import lphs_pkg::*;
#(
    parameter int unsigned TABLE_SIZE  = 23,
    parameter int unsigned KEY_WIDTH   = 16,
    parameter int unsigned HASH_DIGITS = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             req_type,
    input  logic [KEY_PORT_W-1:0]  key,
    output logic                   done,
    output logic                   found,
    output logic                   changed,
    output logic                   table_full,
    output logic [SLOT_PORT_W-1:0] slot
);

    localparam int unsigned SLOT_W = $clog2(TABLE_SIZE);
    localparam int unsigned DIG_W  = (HASH_DIGITS > 1) ? $clog2(HASH_DIGITS) : 1;
    localparam int unsigned SUM_W  = $clog2(9 * HASH_DIGITS + 1);
    localparam int unsigned CMP_W  = SLOT_PORT_W + 2;
    localparam int unsigned PROD_W = KEY_WIDTH + 32;
    localparam int unsigned DATA_W = KEY_WIDTH + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_MOD,
        ST_PROBE
    } state_t;

    state_t                 state_reg;
    req_t                   req_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [KEY_WIDTH-1:0]   cur_reg;
    logic [KEY_WIDTH-1:0]   quo_reg;
    logic [DIG_W-1:0]       dig_reg;
    logic [SUM_W-1:0]       sum_reg;
    logic [SLOT_W-1:0]      pos_reg;
    logic [SLOT_W-1:0]      cnt_reg;
    logic [TABLE_SIZE-1:0]  valid_reg;
    logic                   rd_valid_reg;
    logic                   done_reg;
    logic                   found_reg;
    logic                   changed_reg;
    logic                   full_reg;
    logic [SLOT_PORT_W-1:0] slot_reg;

    logic [KEY_WIDTH-1:0]   key_in;
    logic [PROD_W-1:0]      prod;
    logic [KEY_WIDTH-1:0]   quo_next;
    logic [3:0]             digit;
    logic                   sum_ge;
    logic [SLOT_W-1:0]      pos_inc;
    logic                   last_probe;
    tag_t                   rd_tag;
    logic                   key_hit;
    logic                   probe_store;
    logic                   probe_hit;
    logic                   probe_miss;
    logic                   probe_done;

    logic                   ram_wr_en;
    logic [DATA_W-1:0]      ram_wr_data;
    logic                   ram_rd_en;
    logic [SLOT_W-1:0]      ram_rd_addr;
    logic [DATA_W-1:0]      ram_rd_data;

    assign key_in   = KEY_WIDTH'(key);
    assign prod     = PROD_W'(cur_reg) * PROD_W'(DIV10_RECIP);
    assign quo_next = KEY_WIDTH'(prod >> DIV10_SHIFT);
    assign digit    = 4'(cur_reg - (quo_reg << 3) - (quo_reg << 1));
    assign sum_ge   = CMP_W'(sum_reg) >= CMP_W'(TABLE_SIZE);

    assign pos_inc    = (pos_reg == SLOT_W'(TABLE_SIZE - 1)) ? '0 : pos_reg + 1'b1;
    assign last_probe = cnt_reg == SLOT_W'(TABLE_SIZE - 1);
    assign rd_tag     = rd_valid_reg ? tag_t'(ram_rd_data[DATA_W-1:KEY_WIDTH]) : TAG_EMPTY;
    assign key_hit    = ram_rd_data[KEY_WIDTH-1:0] == key_reg;

    assign probe_store = (req_reg == REQ_INSERT) && (rd_tag != TAG_LIVE);
    assign probe_hit   = (rd_tag == TAG_LIVE) && key_hit;
    assign probe_miss  = (req_reg != REQ_INSERT) && (rd_tag == TAG_EMPTY);
    assign probe_done  = probe_store || probe_hit || probe_miss;

    always_comb
    begin
        ram_rd_en   = 1'b0;
        ram_rd_addr = pos_inc;
        ram_wr_en   = 1'b0;
        ram_wr_data = {probe_store ? TAG_LIVE : TAG_DEAD, key_reg};
        case (state_reg)
            ST_MOD:
            begin
                ram_rd_en   = !sum_ge;
                ram_rd_addr = SLOT_W'(sum_reg);
            end
            ST_PROBE:
            begin
                ram_rd_en = !probe_done && !last_probe;
                ram_wr_en = probe_store || (probe_hit && (req_reg == REQ_DELETE));
            end
            default:
            begin
                ram_rd_en = 1'b0;
            end
        endcase
    end

    lphs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_SIZE)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (pos_reg),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            req_reg      <= REQ_INSERT;
            key_reg      <= '0;
            cur_reg      <= '0;
            quo_reg      <= '0;
            dig_reg      <= '0;
            sum_reg      <= '0;
            pos_reg      <= '0;
            cnt_reg      <= '0;
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            found_reg    <= 1'b0;
            changed_reg  <= 1'b0;
            full_reg     <= 1'b0;
            slot_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ram_rd_en)
            begin
                rd_valid_reg <= valid_reg[ram_rd_addr];
            end
            if (ram_wr_en)
            begin
                valid_reg[pos_reg] <= 1'b1;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        key_reg <= key_in;
                        cur_reg <= key_in;
                        dig_reg <= '0;
                        sum_reg <= '0;
                        if ((key_in == '0) || (req_type == REQ_UNKNOWN))
                        begin
                            // drop: reserved key or unknown request
                            done_reg    <= 1'b1;
                            found_reg   <= 1'b0;
                            changed_reg <= 1'b0;
                            full_reg    <= 1'b0;
                            slot_reg    <= '0;
                        end
                        else
                        begin
                            req_reg   <= req_t'(req_type);
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    quo_reg   <= quo_next;
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    sum_reg <= sum_reg + SUM_W'(digit);
                    cur_reg <= quo_reg;
                    dig_reg <= dig_reg + 1'b1;
                    if (dig_reg == DIG_W'(HASH_DIGITS - 1))
                    begin
                        state_reg <= ST_MOD;
                    end
                    else
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MOD:
                begin
                    if (sum_ge)
                    begin
                        sum_reg <= sum_reg - SUM_W'(TABLE_SIZE);
                    end
                    else
                    begin
                        pos_reg   <= SLOT_W'(sum_reg);
                        cnt_reg   <= '0;
                        state_reg <= ST_PROBE;
                    end
                end
                ST_PROBE:
                begin
                    if (probe_done)
                    begin
                        done_reg    <= 1'b1;
                        found_reg   <= probe_hit;
                        changed_reg <= probe_store || (probe_hit && (req_reg == REQ_DELETE));
                        full_reg    <= 1'b0;
                        slot_reg    <= probe_miss ? '0 : SLOT_PORT_W'(pos_reg);
                        state_reg   <= ST_IDLE;
                    end
                    else if (last_probe)
                    begin
                        done_reg    <= 1'b1;
                        found_reg   <= 1'b0;
                        changed_reg <= 1'b0;
                        full_reg    <= req_reg == REQ_INSERT;
                        slot_reg    <= '0;
                        state_reg   <= ST_IDLE;
                    end
                    else
                    begin
                        // advance to the next slot, read already issued
                        pos_reg <= pos_inc;
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy       = state_reg != ST_IDLE;
    assign done       = done_reg;
    assign found      = found_reg;
    assign changed    = changed_reg;
    assign table_full = full_reg;
    assign slot       = slot_reg;

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the linear probing hash set core: directed and random requests.
`timescale 1ns / 1ps

module tb_top
    import lphs_pkg::*;
();

    localparam int unsigned TABLE_SIZE  = 23;
    localparam int unsigned KEY_WIDTH   = 16;
    localparam int unsigned HASH_DIGITS = 4;
    localparam int unsigned WORK_ITEMS  = 1050;
    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned DRAIN_WAIT  = 40;
    localparam int unsigned N_DIRECTED  = 25;

    typedef struct packed {
        logic                   found;
        logic                   changed;
        logic                   table_full;
        logic [SLOT_PORT_W-1:0] slot;
    } hs_result_t;

    typedef struct packed {
        logic [1:0]            rt;
        logic [KEY_PORT_W-1:0] k;
        logic                  typed;
        hs_result_t            res;
    } dir_row_t;

    localparam hs_result_t MISS = '0;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [1:0]             req_type;
    logic [KEY_PORT_W-1:0]  key;
    logic                   done;
    logic                   found;
    logic                   changed;
    logic                   table_full;
    logic [SLOT_PORT_W-1:0] slot;

    tag_t                  shadow_tag [TABLE_SIZE];
    logic [KEY_PORT_W-1:0] shadow_key [TABLE_SIZE];
    hs_result_t            pending_outcomes [$];

    int unsigned n_errors;
    int unsigned n_beats;
    int unsigned n_work;
    int unsigned n_ignored;
    int unsigned n_hits;
    int unsigned n_stored;
    int unsigned n_full;
    int unsigned idle_cycles;

    dir_row_t dir_rows [N_DIRECTED] = '{
        '{REQ_QUERY,   16'd1,     1'b1, MISS},
        '{REQ_DELETE,  16'd65535, 1'b1, MISS},
        '{REQ_INSERT,  16'd0,     1'b1, MISS},
        '{REQ_UNKNOWN, 16'd5,     1'b1, MISS},
        '{REQ_QUERY,   16'd0,     1'b1, MISS},
        '{REQ_INSERT,  16'd1,     1'b0, MISS},
        '{REQ_INSERT,  16'd1,     1'b0, MISS},
        '{REQ_INSERT,  16'd65535, 1'b0, MISS},
        '{REQ_INSERT,  16'd10,    1'b0, MISS},
        '{REQ_INSERT,  16'd100,   1'b0, MISS},
        '{REQ_DELETE,  16'd1,     1'b0, MISS},
        '{REQ_QUERY,   16'd10,    1'b0, MISS},
        '{REQ_DELETE,  16'd1,     1'b0, MISS},
        '{REQ_INSERT,  16'd1000,  1'b0, MISS},
        '{REQ_INSERT,  16'd100,   1'b0, MISS},
        '{REQ_INSERT,  16'd32768, 1'b0, MISS},
        '{REQ_INSERT,  16'd12345, 1'b0, MISS},
        '{REQ_QUERY,   16'd2345,  1'b0, MISS},
        '{REQ_INSERT,  16'd2345,  1'b0, MISS},
        '{REQ_DELETE,  16'd12345, 1'b0, MISS},
        '{REQ_QUERY,   16'd2345,  1'b0, MISS},
        '{REQ_UNKNOWN, 16'd65535, 1'b1, MISS},
        '{REQ_INSERT,  16'd22,    1'b0, MISS},
        '{REQ_INSERT,  16'd499,   1'b0, MISS},
        '{REQ_INSERT,  16'd589,   1'b0, MISS}
    };

    linear_probe_hash_set_core #(
        .TABLE_SIZE  (TABLE_SIZE),
        .KEY_WIDTH   (KEY_WIDTH),
        .HASH_DIGITS (HASH_DIGITS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .key        (key),
        .done       (done),
        .found      (found),
        .changed    (changed),
        .table_full (table_full),
        .slot       (slot)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned digit_home(input logic [KEY_PORT_W-1:0] k);
        int unsigned v;
        int unsigned sum;
        v = 32'(k);
        sum = 0;
        for (int d = 0; d < HASH_DIGITS; d++)
        begin
            sum += v % 10;
            v /= 10;
        end
        return sum % TABLE_SIZE;
    endfunction

    function automatic hs_result_t apply_to_shadow_set(input logic [1:0] rt,
                                                       input logic [KEY_PORT_W-1:0] k);
        hs_result_t r;
        int unsigned pos;
        r = MISS;
        if (k == '0 || rt == REQ_UNKNOWN)
            return r;
        pos = digit_home(k);
        if (rt == REQ_INSERT)
        begin
            for (int n = 0; n < TABLE_SIZE; n++)
            begin
                if (shadow_tag[pos] != TAG_LIVE)
                begin
                    shadow_tag[pos] = TAG_LIVE;
                    shadow_key[pos] = k;
                    r.changed = 1'b1;
                    r.slot = SLOT_PORT_W'(pos);
                    return r;
                end
                if (shadow_key[pos] == k)
                begin
                    r.found = 1'b1;
                    r.slot = SLOT_PORT_W'(pos);
                    return r;
                end
                pos = (pos + 1) % TABLE_SIZE;
            end
            r.table_full = 1'b1;
            return r;
        end
        for (int n = 0; n < TABLE_SIZE; n++)
        begin
            if (shadow_tag[pos] == TAG_EMPTY)
                return r;
            if (shadow_tag[pos] == TAG_LIVE && shadow_key[pos] == k)
            begin
                r.found = 1'b1;
                r.slot = SLOT_PORT_W'(pos);
                if (rt == REQ_DELETE)
                begin
                    shadow_tag[pos] = TAG_DEAD;
                    r.changed = 1'b1;
                end
                return r;
            end
            pos = (pos + 1) % TABLE_SIZE;
        end
        return r;
    endfunction

    function automatic int unsigned live_count();
        int unsigned c;
        c = 0;
        for (int i = 0; i < TABLE_SIZE; i++)
            if (shadow_tag[i] == TAG_LIVE)
                c++;
        return c;
    endfunction

    function automatic logic [KEY_PORT_W-1:0] pick_live_key();
        int unsigned base;
        int unsigned idx;
        base = $urandom_range(0, TABLE_SIZE - 1);
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            idx = (base + i) % TABLE_SIZE;
            if (shadow_tag[idx] == TAG_LIVE)
                return shadow_key[idx];
        end
        return KEY_PORT_W'($urandom_range(1, 65535));
    endfunction

    function automatic logic [KEY_PORT_W-1:0] pool_key();
        int unsigned r;
        int unsigned v;
        r = $urandom_range(0, 2);
        if (r == 0)
            return KEY_PORT_W'($urandom_range(1, 300));
        if (r == 1)
        begin
            v = $urandom_range(1, 9999) + 10000 * $urandom_range(0, 5);
            return KEY_PORT_W'(v);
        end
        return KEY_PORT_W'($urandom_range(1, 65535));
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH beat %0d: %s got %0d expected %0d", n_beats, what, got, want);
        n_errors++;
    endtask

    task automatic send_request(input logic [1:0] rt, input logic [KEY_PORT_W-1:0] k,
                                input logic typed, input hs_result_t typed_res);
        hs_result_t pred;
        start    <= 1'b1;
        req_type <= rt;
        key      <= k;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pred = apply_to_shadow_set(rt, k);
        pending_outcomes.push_back(typed ? typed_res : pred);
        if (k == '0 || rt == REQ_UNKNOWN)
            n_ignored++;
        else
            n_work++;
        n_hits   += 32'(pred.found);
        n_stored += 32'((rt == REQ_INSERT) && pred.changed);
        n_full   += 32'(pred.table_full);
    endtask

    task automatic request_gap(input bit quiet);
        int unsigned r;
        int unsigned g;
        r = $urandom_range(0, 99);
        g = 0;
        if (!quiet && r >= 60)
            g = (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        if (g != 0)
        begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        hs_result_t want;
        if (rst_n && done)
        begin
            n_beats++;
            if (pending_outcomes.size() == 0)
                report_mismatch("result with nothing pending, slot", 32'(slot), 0);
            else
            begin
                want = pending_outcomes.pop_front();
                if (found !== want.found)
                    report_mismatch("found", 32'(found), 32'(want.found));
                if (changed !== want.changed)
                    report_mismatch("changed", 32'(changed), 32'(want.changed));
                if (table_full !== want.table_full)
                    report_mismatch("table_full", 32'(table_full), 32'(want.table_full));
                if (slot !== want.slot)
                    report_mismatch("slot", 32'(slot), 32'(want.slot));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, pending_outcomes.size());
            $display("linear_probe_hash_set_core test failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned mode;
        int unsigned len;
        int unsigned r;
        int unsigned floor_live;
        bit quiet;
        logic [1:0] rt;
        logic [KEY_PORT_W-1:0] k;
        logic [KEY_PORT_W-1:0] pool [$];

        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = REQ_INSERT;
        key         = '0;
        n_errors    = 0;
        n_beats     = 0;
        n_work      = 0;
        n_ignored   = 0;
        n_hits      = 0;
        n_stored    = 0;
        n_full      = 0;
        idle_cycles = 0;
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            shadow_tag[i] = TAG_EMPTY;
            shadow_key[i] = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            send_request(dir_rows[i].rt, dir_rows[i].k, dir_rows[i].typed, dir_rows[i].res);
            request_gap(1'b0);
        end

        while (n_work < WORK_ITEMS)
        begin
            mode  = $urandom_range(0, 99);
            quiet = ($urandom_range(0, 4) == 0);
            if (mode < 55)
            begin
                // mixed traffic over a small key pool with clustered homes
                pool.delete();
                repeat (24) pool.push_back(pool_key());
                len = $urandom_range(20, 60);
                repeat (len)
                begin
                    r = $urandom_range(0, 99);
                    rt = (r < 40) ? REQ_INSERT : (r < 70) ? REQ_DELETE : REQ_QUERY;
                    r = $urandom_range(0, 99);
                    if (r < 40)
                        k = pick_live_key();
                    else if (r < 85)
                        k = pool[$urandom_range(0, pool.size() - 1)];
                    else
                        k = KEY_PORT_W'($urandom_range(1, 65535));
                    send_request(rt, k, 1'b0, MISS);
                    request_gap(quiet);
                end
            end
            else if (mode < 70)
            begin
                // fill until every slot holds a live key or 40 inserts are sent, then probe a packed table
                len = 0;
                while (live_count() < TABLE_SIZE && len < 40)
                begin
                    send_request(REQ_INSERT, pool_key(), 1'b0, MISS);
                    request_gap(quiet);
                    len++;
                end
                send_request(REQ_INSERT, KEY_PORT_W'($urandom_range(1, 65535)), 1'b0, MISS);
                request_gap(quiet);
                send_request(REQ_INSERT, pick_live_key(), 1'b0, MISS);
                request_gap(quiet);
                send_request(REQ_QUERY, KEY_PORT_W'($urandom_range(1, 65535)), 1'b0, MISS);
                request_gap(quiet);
                send_request(REQ_DELETE, KEY_PORT_W'($urandom_range(1, 65535)), 1'b0, MISS);
                request_gap(quiet);
            end
            else if (mode < 85)
            begin
                // drain live keys, leaving tombstones behind
                floor_live = $urandom_range(0, 8);
                len = 0;
                while (live_count() > floor_live && len < 30)
                begin
                    send_request(REQ_DELETE, pick_live_key(), 1'b0, MISS);
                    request_gap(quiet);
                    len++;
                end
            end
            else
            begin
                // noise: any request code, any key including the reserved one
                len = $urandom_range(3, 10);
                repeat (len)
                begin
                    rt = 2'($urandom_range(0, 3));
                    k = ($urandom_range(0, 3) == 0) ? '0 : KEY_PORT_W'($urandom_range(0, 65535));
                    send_request(rt, k, 1'b0, MISS);
                    request_gap(quiet);
                end
            end
        end
        start <= 1'b0;

        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("run covered %0d requests and %0d ignored beats, %0d results checked",
                 n_work, n_ignored, n_beats);
        $display("hits %0d, keys stored %0d, full-table inserts %0d, mismatches %0d",
                 n_hits, n_stored, n_full, n_errors);
        if (n_errors == 0)
            $display("linear_probe_hash_set_core test passed");
        else
            $display("linear_probe_hash_set_core test failed");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/lphs_pkg.sv
hw/rtl/lphs_ram.sv
hw/rtl/linear_probe_hash_set_core.sv
test/tb_top.sv
